// ===== hw/rtl/dmm_pkg.sv =====
`timescale 1ns / 1ps
package dmm_pkg;
  localparam int Slots = 32;
  localparam int SlotBits = $clog2(Slots);
  localparam int IdBits = 8;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0, ACT_DSEND = 2'd1, ACT_RECV = 2'd2, ACT_TICK = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD_TARGET = 2'd1, ST_FULL = 2'd2, ST_NO_MSG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_HIGHEST = 2'd0, REG_KEYBOARD = 2'd1, REG_CLOCK = 2'd2
  } reg_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic clr_idx;   // restart walk at slot 0
    logic step;      // examine current slot
    logic finish;    // latch result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // walk at last slot
    logic done;      // early finish (send and delayed send always, receive on a match)
  } sts_t;
endpackage

// ===== hw/rtl/delayed_message_mailbox.sv =====
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  action, caller_id, target_id, body_handle, delay_ticks
// out      out_valid_o/out_stall_i status, slot, from_id, body_out, moved_count
// cfg      APB psel/penable/...   highest_user_id, keyboard_task_id, clock_task_id
// One item at a time. Send and delayed send go through accept, one walk step and
// result. Receive walks the ready table one slot a cycle and stops at a match;
// tick always walks all 32 delayed entries. A stalled result holds the block
// until it is taken.
// Reset clears all valid bits and loads register defaults.
// The input is stalled from acceptance until the result is taken.
module delayed_message_mailbox import dmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [IdBits-1:0] caller_id_i,
  input  logic [IdBits-1:0] target_id_i,
  input  logic [31:0]       body_handle_i,
  input  logic [15:0]       delay_ticks_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [4:0]        slot_o,
  output logic [IdBits-1:0] from_id_o,
  output logic [31:0]       body_out_o,
  output logic [5:0]        moved_count_o
);
  logic [IdBits-1:0] highest_q, keyboard_q, clock_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // Register file: word address selects the register, unknown addresses ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= IdBits'(6);
      keyboard_q <= IdBits'(12);
      clock_q <= IdBits'(11);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HIGHEST:  highest_q <= pwdata[IdBits-1:0];
        REG_KEYBOARD: keyboard_q <= pwdata[IdBits-1:0];
        REG_CLOCK:    clock_q <= pwdata[IdBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_HIGHEST:  prdata = 32'(highest_q);
      REG_KEYBOARD: prdata = 32'(keyboard_q);
      REG_CLOCK:    prdata = 32'(clock_q);
      default:      prdata = '0;
    endcase
  end

  dmm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dmm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .highest_i(highest_q), .keyboard_i(keyboard_q), .clock_i(clock_q),
    .action_i, .caller_id_i, .target_id_i, .body_handle_i, .delay_ticks_i,
    .status_o, .slot_o, .from_id_o, .body_out_o, .moved_count_o
  );
endmodule

// ===== hw/rtl/dmm_ctrl.sv =====
`timescale 1ns / 1ps
module dmm_ctrl import dmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_WALK = 3'b010, S_OUT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.done || sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

// ===== hw/rtl/dmm_datapath.sv =====
`timescale 1ns / 1ps
module dmm_datapath import dmm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [IdBits-1:0]   highest_i,
  input  logic [IdBits-1:0]   keyboard_i,
  input  logic [IdBits-1:0]   clock_i,
  input  logic [1:0]          action_i,
  input  logic [IdBits-1:0]   caller_id_i,
  input  logic [IdBits-1:0]   target_id_i,
  input  logic [31:0]         body_handle_i,
  input  logic [15:0]         delay_ticks_i,
  output logic [1:0]          status_o,
  output logic [4:0]          slot_o,
  output logic [IdBits-1:0]   from_id_o,
  output logic [31:0]         body_out_o,
  output logic [5:0]          moved_count_o
);
  logic [Slots-1:0]  rv_q, wv_q;
  logic [IdBits-1:0] rs_q [Slots], rd_q [Slots], ws_q [Slots], wd_q [Slots];
  logic [31:0]       rb_q [Slots], wb_q [Slots];
  logic [15:0]       wt_q [Slots];

  logic [1:0]          act_q;
  logic [IdBits-1:0]   caller_q, target_q;
  logic [31:0]         body_q;
  logic [15:0]         delay_q;
  logic [SlotBits-1:0] idx_q;
  logic [SlotBits:0]   moved_q;

  // lowest free ready and delayed slots, priority encode over valid bits
  logic [SlotBits-1:0] rfree;
  logic                rfull;
  logic [SlotBits-1:0] wfree;
  logic                wfull;
  always_comb begin
    rfree = '0; rfull = 1'b1; wfree = '0; wfull = 1'b1;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!rv_q[i]) begin rfree = SlotBits'(i); rfull = 1'b0; end
      if (!wv_q[i]) begin wfree = SlotBits'(i); wfull = 1'b0; end
    end
  end

  logic tgt_ok;
  assign tgt_ok = (target_q != '0 && target_q <= highest_i) ||
                  target_q == keyboard_i || target_q == clock_i;

  logic rx_hit;
  assign rx_hit = rv_q[idx_q] && rd_q[idx_q] == caller_q;

  logic tk_act, tk_due, tk_move;
  assign tk_act  = wv_q[idx_q];
  assign tk_due  = tk_act && wt_q[idx_q] <= 16'd1;
  assign tk_move = tk_due && !rfull;

  always_comb begin
    sts_o.last = idx_q == SlotBits'(Slots - 1);
    case (act_e'(act_q))
      ACT_SEND, ACT_DSEND: sts_o.done = 1'b1;
      ACT_RECV:            sts_o.done = rx_hit;
      default:             sts_o.done = 1'b0;
    endcase
  end

  // result of the current step, latched on finish
  logic [1:0]        res_status;
  logic [4:0]        res_slot;
  logic [IdBits-1:0] res_from;
  logic [31:0]       res_body;
  logic [5:0]        res_moved;
  always_comb begin
    res_status = ST_OK;
    res_slot = '0;
    res_from = '0;
    res_body = '0;
    res_moved = '0;
    case (act_e'(act_q))
      ACT_SEND: begin
        if (!tgt_ok) res_status = ST_BAD_TARGET;
        else if (rfull) res_status = ST_FULL;
        else res_slot = 5'(rfree);
      end
      ACT_DSEND: begin
        if (!tgt_ok) res_status = ST_BAD_TARGET;
        else if (wfull) res_status = ST_FULL;
        else res_slot = 5'(wfree);
      end
      ACT_RECV: begin
        if (rx_hit) begin
          res_slot = 5'(idx_q);
          res_from = rs_q[idx_q];
          res_body = rb_q[idx_q];
        end else begin
          res_status = ST_NO_MSG;
        end
      end
      default: res_moved = 6'(moved_q + (SlotBits + 1)'(tk_move));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
      wv_q <= '0;
      idx_q <= '0;
      moved_q <= '0;
    end else begin
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
        moved_q <= '0;
      end else if (cmd_i.step && !sts_o.last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.step) begin
        case (act_e'(act_q))
          ACT_SEND:  if (tgt_ok && !rfull) rv_q[rfree] <= 1'b1;
          ACT_DSEND: if (tgt_ok && !wfull) wv_q[wfree] <= 1'b1;
          ACT_RECV:  if (rx_hit) rv_q[idx_q] <= 1'b0;
          default: begin
            if (tk_move) begin
              rv_q[rfree] <= 1'b1;
              wv_q[idx_q] <= 1'b0;
              moved_q <= moved_q + 1'b1;
            end
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      caller_q <= caller_id_i;
      target_q <= target_id_i;
      body_q <= body_handle_i;
      delay_q <= delay_ticks_i;
    end
    if (cmd_i.step) begin
      case (act_e'(act_q))
        ACT_SEND: if (tgt_ok && !rfull) begin
          rs_q[rfree] <= caller_q; rd_q[rfree] <= target_q; rb_q[rfree] <= body_q;
        end
        ACT_DSEND: if (tgt_ok && !wfull) begin
          ws_q[wfree] <= caller_q; wd_q[wfree] <= target_q; wb_q[wfree] <= body_q;
          wt_q[wfree] <= delay_q;
        end
        ACT_RECV: ;
        default: begin
          if (tk_move) begin
            rs_q[rfree] <= ws_q[idx_q]; rd_q[rfree] <= wd_q[idx_q];
            rb_q[rfree] <= wb_q[idx_q];
          end else if (tk_due) begin
            wt_q[idx_q] <= '0;
          end else if (tk_act) begin
            wt_q[idx_q] <= wt_q[idx_q] - 16'd1;
          end
        end
      endcase
    end
    if (cmd_i.finish) begin
      status_o <= res_status;
      slot_o <= res_slot;
      from_id_o <= res_from;
      body_out_o <= res_body;
      moved_count_o <= res_moved;
    end
  end
endmodule

// ===== sim/delayed_message_mailbox_test.sv =====
`timescale 1ns / 1ps
module delayed_message_mailbox_test;
  import dmm_pkg::*;

  // Mirror of the mailbox: both slot tables plus the target registers.
  class mailbox_scoreboard;
    logic [7:0]  highest_id, keyboard_id, clock_id;
    bit          rdy_vld[Slots];
    logic [7:0]  rdy_from[Slots], rdy_to[Slots];
    logic [31:0] rdy_body[Slots];
    bit          dly_vld[Slots];
    logic [7:0]  dly_from[Slots], dly_to[Slots];
    logic [31:0] dly_body[Slots];
    logic [15:0] dly_count[Slots];
    logic [1:0]  want_status[$];
    logic [4:0]  want_slot[$];
    logic [7:0]  want_from[$];
    logic [31:0] want_body[$];
    logic [5:0]  want_moved[$];
    int          errors;
    int          n_ok, n_bad, n_full, n_none, n_moved;

    function void clear_state();
      highest_id = 8'd6; keyboard_id = 8'd12; clock_id = 8'd11;
      foreach (rdy_vld[i]) begin
        rdy_vld[i] = 0;
        dly_vld[i] = 0;
      end
    endfunction

    function bit target_ok(logic [7:0] t);
      return (t >= 1 && t <= highest_id) || t == keyboard_id || t == clock_id;
    endfunction

    function int first_free_ready();
      for (int i = 0; i < Slots; i++) if (!rdy_vld[i]) return i;
      return -1;
    endfunction

    function int first_free_delayed();
      for (int i = 0; i < Slots; i++) if (!dly_vld[i]) return i;
      return -1;
    endfunction

    function int ready_count();
      int n;
      n = 0;
      foreach (rdy_vld[i]) n += rdy_vld[i];
      return n;
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(act_e act, logic [7:0] caller, logic [7:0] target,
                               logic [31:0] body, logic [15:0] delay);
      status_e st;
      int s, moved;
      logic [4:0] slot;
      logic [7:0] from;
      logic [31:0] bout;
      st = ST_OK; slot = '0; from = '0; bout = '0; moved = 0;
      case (act)
        ACT_SEND, ACT_DSEND: begin
          if (!target_ok(target)) begin
            st = ST_BAD_TARGET;
          end else if (act == ACT_SEND) begin
            s = first_free_ready();
            if (s < 0) st = ST_FULL;
            else begin
              rdy_vld[s] = 1; rdy_from[s] = caller; rdy_to[s] = target;
              rdy_body[s] = body; slot = s[4:0];
            end
          end else begin
            s = first_free_delayed();
            if (s < 0) st = ST_FULL;
            else begin
              dly_vld[s] = 1; dly_from[s] = caller; dly_to[s] = target;
              dly_body[s] = body; dly_count[s] = delay; slot = s[4:0];
            end
          end
        end
        ACT_RECV: begin
          st = ST_NO_MSG;
          for (int i = 0; i < Slots; i++) begin
            if (rdy_vld[i] && rdy_to[i] == caller) begin
              rdy_vld[i] = 0; st = ST_OK; slot = i[4:0];
              from = rdy_from[i]; bout = rdy_body[i];
              break;
            end
          end
        end
        default: begin
          // Count down from slot 0; a due entry that finds no room waits at zero.
          for (int i = 0; i < Slots; i++) begin
            if (!dly_vld[i]) continue;
            if (dly_count[i] > 1) begin
              dly_count[i]--;
              continue;
            end
            s = first_free_ready();
            if (s < 0) begin
              dly_count[i] = 0;
              continue;
            end
            rdy_vld[s] = 1; rdy_from[s] = dly_from[i]; rdy_to[s] = dly_to[i];
            rdy_body[s] = dly_body[i]; dly_vld[i] = 0; moved++;
          end
          n_moved += moved;
        end
      endcase
      case (st)
        ST_OK: n_ok++;
        ST_BAD_TARGET: n_bad++;
        ST_FULL: n_full++;
        default: n_none++;
      endcase
      want_status.push_back(st); want_slot.push_back(slot); want_from.push_back(from);
      want_body.push_back(bout); want_moved.push_back(moved[5:0]);
    endfunction

    function void check_result(logic [1:0] st, logic [4:0] slot, logic [7:0] from,
                               logic [31:0] bout, logic [5:0] moved);
      logic [1:0] e_st;
      logic [4:0] e_slot;
      logic [7:0] e_from;
      logic [31:0] e_body;
      logic [5:0] e_moved;
      if (want_status.size() == 0) begin
        $error("result with no request pending: status %0d", st);
        errors++;
        return;
      end
      e_st = want_status.pop_front(); e_slot = want_slot.pop_front();
      e_from = want_from.pop_front(); e_body = want_body.pop_front();
      e_moved = want_moved.pop_front();
      if (st !== e_st) begin
        $error("status: expected %0d, got %0d", e_st, st); errors++;
      end
      if (slot !== e_slot) begin
        $error("slot: expected %0d, got %0d", e_slot, slot); errors++;
      end
      if (from !== e_from) begin
        $error("from_id: expected %0d, got %0d", e_from, from); errors++;
      end
      if (bout !== e_body) begin
        $error("body_out: expected %h, got %h", e_body, bout); errors++;
      end
      if (moved !== e_moved) begin
        $error("moved_count: expected %0d, got %0d", e_moved, moved); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [1:0] action = '0;
  logic [7:0] caller = '0, target = '0;
  logic [31:0] body = '0;
  logic [15:0] delay = '0;
  logic out_valid, out_stall = 0;
  logic [1:0] status;
  logic [4:0] slot;
  logic [7:0] from_id;
  logic [31:0] body_out;
  logic [5:0] moved;

  mailbox_scoreboard mbox = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;
  int items = 0;

  always #1 clk = ~clk;

  delayed_message_mailbox dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .caller_id_i(caller), .target_id_i(target),
    .body_handle_i(body), .delay_ticks_i(delay),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .slot_o(slot), .from_id_o(from_id),
    .body_out_o(body_out), .moved_count_o(moved)
  );

  // Receiver: stall at random, or hold off entirely while hold_off is set.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mbox.check_result(status, slot, from_id, body_out, moved);
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [7:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_HIGHEST: mbox.highest_id = value;
      REG_KEYBOARD: mbox.keyboard_id = value;
      default: mbox.clock_id = value;
    endcase
  endtask

  // Offer one item; hold it until accepted, then note it.
  task automatic send_item(act_e act, logic [7:0] c, logic [7:0] t,
                           logic [31:0] b, logic [15:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; action <= act; caller <= c; target <= t; body <= b; delay <= d;
    do @(posedge clk); while (in_stall);
    mbox.note_request(act, c, t, b, d);
    items++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (mbox.want_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Pick a mostly legal target, sometimes anything at all.
  function automatic logic [7:0] pick_target();
    case ($urandom_range(9))
      0: return mbox.keyboard_id;
      1: return mbox.clock_id;
      2, 3: return 8'($urandom_range(255));
      default: return 8'($urandom_range(mbox.highest_id, 1));
    endcase
  endfunction

  // Random traffic: callers mostly picked the same way as targets so receives hit.
  task automatic random_items(int n);
    int r;
    act_e act;
    logic [7:0] t;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      act = r < 30 ? ACT_SEND : r < 50 ? ACT_DSEND : r < 82 ? ACT_RECV : ACT_TICK;
      t = pick_target();
      send_item(act, $urandom_range(3) == 0 ? 8'($urandom_range(255)) : pick_target(), t,
                $urandom(),
                $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(4)));
    end
  endtask

  initial begin
    mbox.clear_state();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: invalid targets at the edges, fills, receives, ticks.
    send_item(ACT_SEND, 8'd0, 8'd0, 32'hFFFF_FFFF, 16'd0);
    send_item(ACT_SEND, 8'd255, 8'd255, 32'h0, 16'hFFFF);
    send_item(ACT_SEND, 8'd255, 8'd6, 32'hFFFF_FFFF, 16'd0);
    send_item(ACT_SEND, 8'd3, 8'd12, 32'hA5A5_5A5A, 16'd0);
    send_item(ACT_SEND, 8'd4, 8'd11, 32'h5A5A_A5A5, 16'd0);
    send_item(ACT_RECV, 8'd6, 8'd0, 32'h0, 16'd0);
    send_item(ACT_RECV, 8'd6, 8'd0, 32'h0, 16'd0);
    send_item(ACT_DSEND, 8'd1, 8'd12, 32'h1234_5678, 16'd0);
    send_item(ACT_DSEND, 8'd2, 8'd1, 32'h8765_4321, 16'd2);
    send_item(ACT_DSEND, 8'd2, 8'd7, 32'h0, 16'hFFFF);
    send_item(ACT_TICK, 8'd0, 8'd0, 32'h0, 16'd0);
    send_item(ACT_TICK, 8'd0, 8'd0, 32'h0, 16'd0);
    send_item(ACT_RECV, 8'd12, 8'd0, 32'h0, 16'd0);
    send_item(ACT_RECV, 8'd1, 8'd0, 32'h0, 16'd0);
    // Fill both tables to overflow, then let due entries wait for room.
    for (int k = 0; k < 33; k++) send_item(ACT_SEND, 8'd9, 8'd5, $urandom(), 16'd0);
    for (int k = 0; k < 33; k++) send_item(ACT_DSEND, 8'd8, 8'd2, $urandom(), 16'd1);
    send_item(ACT_TICK, 8'd0, 8'd0, 32'h0, 16'd0);
    for (int k = 0; k < 3; k++) send_item(ACT_RECV, 8'd5, 8'd0, 32'h0, 16'd0);
    send_item(ACT_TICK, 8'd0, 8'd0, 32'h0, 16'd0);
    // Pick up the two early messages to the special ids, then empty the rest.
    send_item(ACT_RECV, 8'd12, 8'd0, 32'h0, 16'd0);
    send_item(ACT_RECV, 8'd11, 8'd0, 32'h0, 16'd0);
    while (mbox.ready_count() > 0) send_item(ACT_RECV, $urandom_range(1) ? 8'd5 : 8'd2,
                                             8'd0, 32'h0, 16'd0);
    for (int k = 0; k < 12; k++) begin
      send_item(ACT_TICK, 8'd0, 8'd0, 32'h0, 16'd0);
      for (int j = 0; j < 3; j++) send_item(ACT_RECV, 8'd2, 8'd0, 32'h0, 16'd0);
    end
    drain();

    // Phase A: sender idles lightly, receiver heavily; default registers.
    send_idle_pct = 16; recv_idle_pct = 69;
    random_items(280);
    drain();

    // Phase B: swap idling; widest and narrowest target settings.
    write_reg(REG_HIGHEST, 8'd255);
    write_reg(REG_KEYBOARD, 8'd0);
    write_reg(REG_CLOCK, 8'd255);
    send_idle_pct = 69; recv_idle_pct = 16;
    random_items(250);
    drain();
    write_reg(REG_HIGHEST, 8'd1);
    write_reg(REG_KEYBOARD, 8'd200);
    write_reg(REG_CLOCK, 8'd0);
    random_items(150);
    drain();

    // Phase C: no idling; receiver holds off for a long stretch meanwhile.
    write_reg(REG_HIGHEST, 8'd20);
    write_reg(REG_KEYBOARD, 8'd12);
    write_reg(REG_CLOCK, 8'd11);
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_items(180);
    join
    drain();

    $display("Covered %0d requests: %0d ok, %0d bad target, %0d full, %0d no message,",
             items, mbox.n_ok, mbox.n_bad, mbox.n_full, mbox.n_none);
    $display("  %0d delayed messages moved on tick, over four register settings.",
             mbox.n_moved);
    if (mbox.errors == 0 && mbox.want_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
